// ----- rtl/analog_keypad_code_lock_assert.svh -----
// ----------------------------------------------------------------------------
// analog_keypad_code_lock assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ANALOG_KEYPAD_CODE_LOCK_ASSERT_SVH
`define ANALOG_KEYPAD_CODE_LOCK_ASSERT_SVH

// property must hold at every clock edge out of reset
`define AKCL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("akcl assertion failed");

// condition must never be seen at a clock edge out of reset
`define AKCL_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("akcl forbidden condition seen");

`endif

// ----- rtl/akcl_pkg.sv -----
// ----------------------------------------------------------------------------
// akcl_pkg
// word types, codes and register reset values of the keypad code lock
// ----------------------------------------------------------------------------
`default_nettype none

package akcl_pkg;

  // input word kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_LOCK   = 2'd1,
    KIND_UNLOCK = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  // attempt outcome codes
  typedef enum logic [1:0] {
    OUTCOME_NONE     = 2'd0,
    OUTCOME_UNLOCKED = 2'd1,
    OUTCOME_RELOCKED = 2'd2,
    OUTCOME_REJECTED = 2'd3
  } outcome_e;

  // register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_KEY2_THR    = 3'd0,
    REG_KEY3_THR    = 3'd1,
    REG_KEY4_THR    = 3'd2,
    REG_RELEASE_THR = 3'd3,
    REG_UNLOCK_CODE = 3'd4,
    REG_RELOCK_CODE = 3'd5,
    REG_DECOY_CODE  = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_e;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0]  Key2ThrReset    = 8'h40;
  localparam logic [7:0]  Key3ThrReset    = 8'h95;
  localparam logic [7:0]  Key4ThrReset    = 8'hb4;
  localparam logic [7:0]  ReleaseThrReset = 8'he5;
  localparam logic [15:0] UnlockCodeReset = 16'd4938;
  localparam logic [15:0] RelockCodeReset = 16'd30931;
  localparam logic [15:0] DecoyCodeReset  = 16'd52844;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic       key_accepted;
    logic [2:0] key_value;
    logic       attempt_done;
    logic [1:0] outcome;
    logic       decoy_hit;
    logic       is_unlocked;
  } out_word_t;

endpackage

`default_nettype wire

// ----- rtl/analog_keypad_code_lock.sv -----
// path: an accepted word waits in the input register, is decoded and judged
//   there, and its result word is held in and offered from the result register
// throughput: one word per cycle; the input register and the result register
//   both advance together whenever the result register is free or being taken
// reset: asynchronous, active low; lock comes up locked with the key count,
//   pending candidate and confirmed press cleared and registers at defaults
`default_nettype none

// ----------------------------------------------------------------------------
// analog_keypad_code_lock
// resistor-ladder keypad decoder with debounce, CODE_LENGTH-key (eight by default) code buffer and
// lock / unlock / decoy code judging, APB register port for thresholds/codes
// ----------------------------------------------------------------------------
module analog_keypad_code_lock #(
  parameter int unsigned CODE_LENGTH = 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // input word channel
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  akcl_pkg::in_word_t       in_word_i,
  // result word channel
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output akcl_pkg::out_word_t            out_word_o,
  // register port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [akcl_pkg::AddrWidth-1:0] paddr,
  input  wire  [akcl_pkg::DataWidth-1:0] pwdata,
  output logic [akcl_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);
  import akcl_pkg::*;

  localparam int unsigned IdxW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(CODE_LENGTH - 1);

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  logic [7:0]  key2_thr_q, key3_thr_q, key4_thr_q, release_thr_q;
  logic [15:0] unlock_code_q, relock_code_q, decoy_code_q;
  logic        cfg_write;
  reg_idx_e    cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key2_thr_q    <= Key2ThrReset;
      key3_thr_q    <= Key3ThrReset;
      key4_thr_q    <= Key4ThrReset;
      release_thr_q <= ReleaseThrReset;
      unlock_code_q <= UnlockCodeReset;
      relock_code_q <= RelockCodeReset;
      decoy_code_q  <= DecoyCodeReset;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_KEY2_THR:    key2_thr_q    <= pwdata[7:0];
        REG_KEY3_THR:    key3_thr_q    <= pwdata[7:0];
        REG_KEY4_THR:    key4_thr_q    <= pwdata[7:0];
        REG_RELEASE_THR: release_thr_q <= pwdata[7:0];
        REG_UNLOCK_CODE: unlock_code_q <= pwdata[15:0];
        REG_RELOCK_CODE: relock_code_q <= pwdata[15:0];
        REG_DECOY_CODE:  decoy_code_q  <= pwdata[15:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY2_THR:    prdata = {24'd0, key2_thr_q};
      REG_KEY3_THR:    prdata = {24'd0, key3_thr_q};
      REG_KEY4_THR:    prdata = {24'd0, key4_thr_q};
      REG_RELEASE_THR: prdata = {24'd0, release_thr_q};
      REG_UNLOCK_CODE: prdata = {16'd0, unlock_code_q};
      REG_RELOCK_CODE: prdata = {16'd0, relock_code_q};
      REG_DECOY_CODE:  prdata = {16'd0, decoy_code_q};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // input register and result register handshake
  // --------------------------------------------------------------------------
  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t out_word_d;
  logic      advance;   // the held input word is processed this cycle
  logic      in_take;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take || advance) begin
        in_valid_q <= in_take;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // --------------------------------------------------------------------------
  // keypad state
  // --------------------------------------------------------------------------
  logic [1:0]      key_buf_q [CODE_LENGTH];  // key minus one per position
  logic [IdxW-1:0] count_q, count_d;
  logic            cand_q, cand_d;           // candidate key seen once
  logic            press_q, press_d;         // press confirmed, wait release
  logic            unlocked_q, unlocked_d;
  logic            buf_write;
  logic [1:0]      buf_wdata;

  // priority chain over the thresholds, first one the sample is below wins
  logic [2:0] key;
  logic       key_hit;
  logic [1:0] key_code;

  always_comb begin
    if (in_word_q.adc_sample < key2_thr_q) begin
      key = 3'd1;
    end else if (in_word_q.adc_sample < key3_thr_q) begin
      key = 3'd2;
    end else if (in_word_q.adc_sample < key4_thr_q) begin
      key = 3'd3;
    end else if (in_word_q.adc_sample < release_thr_q) begin
      key = 3'd4;
    end else begin
      key = 3'd0;
    end
  end

  assign key_hit  = (key != 3'd0);
  assign key_code = key[1:0] - 2'd1;

  // parallel compare of the stored attempt against the three codes;
  // positions past eight only match key 1
  logic [CODE_LENGTH-1:0] unlock_eq, relock_eq, decoy_eq;

  for (genvar gi = 0; gi < CODE_LENGTH; gi++) begin : g_cmp
    if (gi < 8) begin : g_coded
      assign unlock_eq[gi] = (key_buf_q[gi] == unlock_code_q[2*gi +: 2]);
      assign relock_eq[gi] = (key_buf_q[gi] == relock_code_q[2*gi +: 2]);
      assign decoy_eq[gi]  = (key_buf_q[gi] == decoy_code_q[2*gi +: 2]);
    end else begin : g_zero
      assign unlock_eq[gi] = (key_buf_q[gi] == 2'd0);
      assign relock_eq[gi] = (key_buf_q[gi] == 2'd0);
      assign decoy_eq[gi]  = (key_buf_q[gi] == 2'd0);
    end
  end

  // one step of the lock for the held word
  logic confirm;
  logic release_now;

  always_comb begin
    count_d    = count_q;
    cand_d     = cand_q;
    press_d    = press_q;
    unlocked_d = unlocked_q;
    buf_write  = 1'b0;
    buf_wdata  = key_code;
    confirm    = 1'b0;
    release_now = 1'b0;
    out_word_d = '0;

    case (kind_e'(in_word_q.kind))
      KIND_LOCK:   unlocked_d = 1'b0;
      KIND_UNLOCK: unlocked_d = 1'b1;
      KIND_SAMPLE: begin
        // second sample of the pending key confirms the press
        confirm = cand_q & key_hit & (key_buf_q[count_q] == key_code);
        if (confirm) begin
          cand_d  = 1'b0;
          press_d = 1'b1;
        end
        // new candidate while no press is confirmed
        if (!(press_q || confirm) && key_hit) begin
          buf_write = 1'b1;
          cand_d    = 1'b1;
        end
        // release after a confirmed press stores the key
        release_now = press_q & ~key_hit;
        if (release_now) begin
          press_d                 = 1'b0;
          out_word_d.key_accepted = 1'b1;
          out_word_d.key_value    = {1'b0, key_buf_q[count_q]} + 3'd1;
          if (count_q == LastSlot) begin
            count_d                 = '0;
            out_word_d.attempt_done = 1'b1;
            if (unlocked_q) begin
              if (&relock_eq) begin
                unlocked_d         = 1'b0;
                out_word_d.outcome = OUTCOME_RELOCKED;
              end else begin
                out_word_d.outcome = OUTCOME_REJECTED;
              end
            end else begin
              out_word_d.decoy_hit = &decoy_eq;
              if (&unlock_eq) begin
                unlocked_d         = 1'b1;
                out_word_d.outcome = OUTCOME_UNLOCKED;
              end else begin
                out_word_d.outcome = OUTCOME_REJECTED;
              end
            end
          end else begin
            count_d = count_q + IdxW'(1);
          end
        end
      end
      default: ;  // unused kind leaves all state alone
    endcase

    out_word_d.is_unlocked = unlocked_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      cand_q     <= 1'b0;
      press_q    <= 1'b0;
      unlocked_q <= 1'b0;
    end else if (advance) begin
      count_q    <= count_d;
      cand_q     <= cand_d;
      press_q    <= press_d;
      unlocked_q <= unlocked_d;
    end
  end

  // key buffer holds no reset, every entry is written before it is read
  always_ff @(posedge clk_i) begin
    if (advance && buf_write) begin
      key_buf_q[count_q] <= buf_wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/akcl_checker.sv -----
`default_nettype none

// ----------------------------------------------------------------------------
// akcl_checker
// port-level checks of the keypad code lock, bound to the top level
// ----------------------------------------------------------------------------
`include "analog_keypad_code_lock_assert.svh"

module akcl_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            out_valid_o,
  input  wire                            out_stall_i,
  input  wire  akcl_pkg::out_word_t      out_word_o
);
  import akcl_pkg::*;

  logic key_field_bad;
  logic done_field_bad;
  logic lock_field_bad;

  // key value nonzero exactly when a key was stored
  assign key_field_bad = out_word_o.key_accepted != (out_word_o.key_value != 3'd0);

  // judgment only together with a stored key
  assign done_field_bad =
      (out_word_o.attempt_done != (out_word_o.outcome != OUTCOME_NONE)) ||
      (out_word_o.attempt_done && !out_word_o.key_accepted);

  // outcome against lock state, decoy never with a relock and only on a judged attempt
  assign lock_field_bad =
      (out_word_o.outcome == OUTCOME_UNLOCKED && !out_word_o.is_unlocked) ||
      (out_word_o.outcome == OUTCOME_RELOCKED && out_word_o.is_unlocked) ||
      (out_word_o.decoy_hit && out_word_o.outcome == OUTCOME_RELOCKED) ||
      (out_word_o.decoy_hit && !out_word_o.attempt_done);

  // stalled result word holds
  `AKCL_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))

  // key value shown exactly when a key was stored
  `AKCL_ASSERT_NEVER(a_key_value, out_valid_o && key_field_bad)

  // attempt judgment only on a step that stored a key
  `AKCL_ASSERT_NEVER(a_done_outcome, out_valid_o && done_field_bad)

  // outcome agrees with lock state, decoy never on a relock
  `AKCL_ASSERT_NEVER(a_lock_state, out_valid_o && lock_field_bad)

endmodule

bind analog_keypad_code_lock akcl_checker u_akcl_checker (.*);

`default_nettype wire
